/* rtl/deq_pkg.sv */
// ----------------------------------------------------------------------------
// Deque engine package
// Command and status codes shared by the deque engine.
// ----------------------------------------------------------------------------
package deq_pkg;

  localparam logic [3:0] CMD_PUSH_FRONT = 4'd0;
  localparam logic [3:0] CMD_PUSH_REAR  = 4'd1;
  localparam logic [3:0] CMD_POP_FRONT  = 4'd2;
  localparam logic [3:0] CMD_POP_REAR   = 4'd3;
  localparam logic [3:0] CMD_FIRST_POS  = 4'd4;
  localparam logic [3:0] CMD_LAST_POS   = 4'd5;
  localparam logic [3:0] CMD_COUNT      = 4'd6;
  localparam logic [3:0] CMD_MIN        = 4'd7;
  localparam logic [3:0] CMD_MAX        = 4'd8;
  localparam logic [3:0] CMD_READ_KTH   = 4'd9;
  localparam logic [3:0] CMD_DELETE_KTH = 4'd10;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_EMPTY     = 3'd1;
  localparam logic [2:0] ST_FULL      = 3'd2;
  localparam logic [2:0] ST_NOT_FOUND = 3'd3;
  localparam logic [2:0] ST_BAD_INDEX = 3'd4;

  localparam logic signed [31:0] EMPTY_MIN = 32'sd999999;
  localparam logic signed [31:0] EMPTY_MAX = -32'sd999999;

endpackage

/* rtl/double_ended_queue_engine.sv */
// ----------------------------------------------------------------------------
// Double-ended queue engine
// Bounded deque of signed 32-bit words in a circular single-port-read memory.
// ----------------------------------------------------------------------------
// Usage:
//   Raise start with command, value and index while busy is low; the request
//   is taken at that edge and busy rises the next cycle. When the request is
//   done, done pulses for one cycle with data_out, position, match_count,
//   status, occupancy and is_empty valid; busy falls in the same cycle.
//   The receiver cannot stall: results must be captured at the done cycle.
// Sequencing:
//   Push, empty pop, empty min or max, bad index and requests that touch no
//   entry go straight to the done state. Pop and read k-th make a single
//   read (state S_ONE). Searches and count walk the occupied entries one
//   per cycle through the memory read port; min and max likewise when not empty.
//   Delete k-th moves each later entry one place forward, a read and a
//   write per entry.
//   One request is in flight at a time.
// Reset:
//   rst (synchronous) empties the deque: head and count clear. Memory
//   contents are not cleared; only occupied entries are ever reported.
// ----------------------------------------------------------------------------
module double_ended_queue_engine #(
  parameter int DEPTH = 1024
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  output logic                         busy,
  output logic                         done,
  input  logic [3:0]                   command,
  input  logic signed [31:0]           value,
  input  logic [$clog2(DEPTH+1)-1:0]   index,
  output logic signed [31:0]           data_out,
  output logic [$clog2(DEPTH+1)-1:0]   position,
  output logic [$clog2(DEPTH+1)-1:0]   match_count,
  output logic [2:0]                   status,
  output logic [$clog2(DEPTH+1)-1:0]   occupancy,
  output logic                         is_empty
);
  import deq_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_WALK  = 3'd1;  // read issued for entry walk_i
  localparam logic [2:0] S_DREAD = 3'd2;  // delete: read entry walk_i+1
  localparam logic [2:0] S_DWRT  = 3'd3;  // delete: write it to walk_i
  localparam logic [2:0] S_ONE   = 3'd4;  // single read in flight
  localparam logic [2:0] S_DONE  = 3'd5;

  logic signed [31:0] mem [DEPTH];
  logic signed [31:0] rdata;
  logic [AW-1:0]      raddr;
  logic               rd_en;
  logic [AW-1:0]      waddr;
  logic signed [31:0] wdata;
  logic               wr_en;

  logic [2:0]          state;
  logic [AW-1:0]       head;
  logic [CW-1:0]       count;
  logic [3:0]          cmd;
  logic signed [31:0]  val;
  logic [CW-1:0]       walk_i;     // logical index of read in flight
  logic [CW-1:0]       walk_n;     // next logical index to issue
  logic                rd_pend;
  logic                first_seen;

  logic signed [31:0]  res_data;
  logic [CW-1:0]       res_pos;
  logic [CW-1:0]       res_cnt;
  logic [2:0]          res_st;

  // Map a logical index to a physical slot; wraps once at most.
  function automatic logic [AW-1:0] slot_of(input logic [AW-1:0] h,
                                            input logic [CW-1:0] i);
    logic [CW:0] s;
    s = {1'b0, {(CW-AW){1'b0}}, h} + {1'b0, i};
    if (s >= {1'b0, DEPTH_C}) s = s - {1'b0, DEPTH_C};
    return s[AW-1:0];
  endfunction

  function automatic logic [AW-1:0] dec_ptr(input logic [AW-1:0] h);
    return (h == '0) ? AW'(DEPTH - 1) : h - AW'(1);
  endfunction

  function automatic logic [AW-1:0] inc_ptr(input logic [AW-1:0] h);
    return (h == AW'(DEPTH - 1)) ? '0 : h + AW'(1);
  endfunction

  always_ff @(posedge clk) begin
    if (wr_en) mem[waddr] <= wdata;
    if (rd_en) rdata <= mem[raddr];
  end

  assign busy = (state != S_IDLE);
  assign occupancy = count;
  assign is_empty = (count == '0);

  // Memory port controls
  always_comb begin
    rd_en = 1'b0;
    raddr = '0;
    wr_en = 1'b0;
    waddr = '0;
    wdata = val;
    case (state)
      S_IDLE: begin
        if (start) begin
          case (command)
            CMD_PUSH_FRONT: begin
              wr_en = (count < DEPTH_C);
              waddr = dec_ptr(head);
              wdata = value;
            end
            CMD_PUSH_REAR: begin
              wr_en = (count < DEPTH_C);
              waddr = slot_of(head, count);
              wdata = value;
            end
            CMD_POP_FRONT: begin
              rd_en = 1'b1;
              raddr = head;
            end
            CMD_POP_REAR: begin
              rd_en = 1'b1;
              raddr = slot_of(head, count - CW'(1));
            end
            CMD_READ_KTH, CMD_DELETE_KTH: begin
              rd_en = 1'b1;
              raddr = slot_of(head, index - CW'(1));
            end
            default: ;
          endcase
        end
      end
      S_WALK: begin
        rd_en = (walk_n < count);
        raddr = slot_of(head, (cmd == CMD_LAST_POS) ? count - CW'(1) - walk_n
                                                      : walk_n);
      end
      S_DREAD: begin
        rd_en = 1'b1;
        raddr = slot_of(head, walk_i + CW'(1));
      end
      S_DWRT: begin
        wr_en = 1'b1;
        waddr = slot_of(head, walk_i);
        wdata = rdata;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      head  <= '0;
      count <= '0;
      done  <= 1'b0;
      rd_pend <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        S_IDLE: begin
          if (start) begin
            cmd <= command;
            val <= value;
            res_data <= '0;
            res_pos <= '0;
            res_cnt <= '0;
            res_st <= ST_OK;
            walk_i <= '0;
            walk_n <= '0;
            rd_pend <= 1'b0;
            first_seen <= 1'b0;
            state <= S_DONE;
            case (command)
              CMD_PUSH_FRONT, CMD_PUSH_REAR: begin
                if (count >= DEPTH_C) begin
                  res_st <= ST_FULL;
                end else begin
                  if (command == CMD_PUSH_FRONT) head <= dec_ptr(head);
                  count <= count + CW'(1);
                end
              end
              CMD_POP_FRONT, CMD_POP_REAR: begin
                if (count == '0) res_st <= ST_EMPTY;
                else state <= S_ONE;
              end
              CMD_FIRST_POS, CMD_LAST_POS: begin
                res_st <= ST_NOT_FOUND;
                state <= S_WALK;
              end
              CMD_COUNT: state <= S_WALK;
              CMD_MIN, CMD_MAX: begin
                if (count == '0) begin
                  res_st <= ST_EMPTY;
                  res_data <= (command == CMD_MIN) ? EMPTY_MIN : EMPTY_MAX;
                end else begin
                  state <= S_WALK;
                end
              end
              CMD_READ_KTH, CMD_DELETE_KTH: begin
                if (index == '0 || index > count) res_st <= ST_BAD_INDEX;
                else begin
                  state <= S_ONE;
                  walk_i <= index - CW'(1);
                end
              end
              default: ;
            endcase
          end
        end
        S_ONE: begin
          // rdata now holds the addressed entry
          res_data <= rdata;
          state <= S_DONE;
          case (cmd)
            CMD_POP_FRONT: begin
              head <= inc_ptr(head);
              count <= count - CW'(1);
            end
            CMD_POP_REAR: count <= count - CW'(1);
            CMD_DELETE_KTH: begin
              if (walk_i + CW'(1) < count) state <= S_DREAD;
              else count <= count - CW'(1);
            end
            default: ;
          endcase
        end
        S_DREAD: state <= S_DWRT;
        S_DWRT: begin
          // advance the gap one place toward the rear
          if (walk_i + CW'(2) < count) begin
            walk_i <= walk_i + CW'(1);
            state <= S_DREAD;
          end else begin
            count <= count - CW'(1);
            state <= S_DONE;
          end
        end
        S_WALK: begin
          // issue next read, evaluate the one that returned
          rd_pend <= (walk_n < count);
          if (walk_n < count) walk_n <= walk_n + CW'(1);
          walk_i <= walk_n;
          if (rd_pend) begin
            case (cmd)
              CMD_FIRST_POS: begin
                if (!first_seen && rdata == val) begin
                  first_seen <= 1'b1;
                  res_pos <= walk_i + CW'(1);
                  res_st <= ST_OK;
                end
              end
              CMD_LAST_POS: begin
                if (!first_seen && rdata == val) begin
                  first_seen <= 1'b1;
                  res_pos <= count - walk_i;
                  res_st <= ST_OK;
                end
              end
              CMD_COUNT: if (rdata == val) res_cnt <= res_cnt + CW'(1);
              CMD_MIN: if (walk_i == '0 || rdata < res_data) res_data <= rdata;
              CMD_MAX: if (walk_i == '0 || rdata > res_data) res_data <= rdata;
              default: ;
            endcase
          end
          if (!(walk_n < count) && !rd_pend) state <= S_DONE;
        end
        S_DONE: begin
          done <= 1'b1;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign data_out = res_data;
  assign position = res_pos;
  assign match_count = res_cnt;
  assign status = res_st;

  a_done_one_cycle: assert property (@(posedge clk) disable iff (rst)
    done |=> !done) else $error("done held for two cycles");
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= DEPTH_C) else $error("occupancy beyond depth");
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> state == S_IDLE) else $error("done while still busy");
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy) else $error("accepted request not taken");

endmodule

/* tb/sv/double_ended_queue_engine_tb.sv */
// ----------------------------------------------------------------------------
// Double-ended queue engine testbench
// Drives push, pop, search, count, min/max, read and delete requests into the
// deque engine, predicts every response from an in-bench deque model, and
// compares each response field by field as the done strobe marks it.
// ----------------------------------------------------------------------------
module double_ended_queue_engine_tb;
  import deq_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int DEPTH    = 1024;
  localparam int IDX_W    = $clog2(DEPTH + 1);
  localparam int WDOG_MAX = 20000;   // longest request: delete at full

  typedef struct packed {
    logic signed [31:0] data;
    logic [IDX_W-1:0]   pos;
    logic [IDX_W-1:0]   cnt;
    logic [2:0]         st;
    logic [IDX_W-1:0]   occ;
    logic               empty;
  } deq_resp_t;

  logic                     clk;
  logic                     rst;
  logic                     start;
  logic                     busy;
  logic                     done;
  logic [3:0]               command;
  logic signed [31:0]       value;
  logic [IDX_W-1:0]         index;
  logic signed [31:0]       data_out;
  logic [IDX_W-1:0]         position;
  logic [IDX_W-1:0]         match_count;
  logic [2:0]               status;
  logic [IDX_W-1:0]         occupancy;
  logic                     is_empty;

  // Shadow of the deque contents, front at index 0.
  logic signed [31:0] shadow_deque[$];
  // Responses predicted but not yet seen on the outputs.
  deq_resp_t          pending_resp[$];

  int  n_requests = 0;
  int  n_checked = 0;
  int  n_errors = 0;
  int  idle_cycles = 0;
  bit  allow_gaps;

  double_ended_queue_engine #(.DEPTH(DEPTH)) dut (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .done        (done),
    .command     (command),
    .value       (value),
    .index       (index),
    .data_out    (data_out),
    .position    (position),
    .match_count (match_count),
    .status      (status),
    .occupancy   (occupancy),
    .is_empty    (is_empty)
  );

  always begin
    clk = 1'b1; #1;
    clk = 1'b0; #1;
  end

  // Apply one request to the shadow deque and return the response it owes.
  function automatic deq_resp_t apply_request(logic [3:0] cmd, logic signed [31:0] val,
                                               logic [IDX_W-1:0] k);
    deq_resp_t r;
    int        n;
    r = '0;
    n = shadow_deque.size();
    case (cmd)
      CMD_PUSH_FRONT, CMD_PUSH_REAR: begin
        if (n >= DEPTH) r.st = ST_FULL;
        else if (cmd == CMD_PUSH_FRONT) shadow_deque.push_front(val);
        else shadow_deque.push_back(val);
      end
      CMD_POP_FRONT, CMD_POP_REAR: begin
        if (n == 0) r.st = ST_EMPTY;
        else if (cmd == CMD_POP_FRONT) r.data = shadow_deque.pop_front();
        else r.data = shadow_deque.pop_back();
      end
      CMD_FIRST_POS: begin
        r.st = ST_NOT_FOUND;
        for (int i = 0; i < n; i++) begin
          if (shadow_deque[i] == val) begin
            r.pos = IDX_W'(i + 1);
            r.st  = ST_OK;
            break;
          end
        end
      end
      CMD_LAST_POS: begin
        r.st = ST_NOT_FOUND;
        for (int i = n - 1; i >= 0; i--) begin
          if (shadow_deque[i] == val) begin
            r.pos = IDX_W'(i + 1);
            r.st  = ST_OK;
            break;
          end
        end
      end
      CMD_COUNT: begin
        foreach (shadow_deque[i]) if (shadow_deque[i] == val) r.cnt++;
      end
      CMD_MIN, CMD_MAX: begin
        if (n == 0) begin
          r.st   = ST_EMPTY;
          r.data = (cmd == CMD_MIN) ? EMPTY_MIN : EMPTY_MAX;
        end else begin
          r.data = shadow_deque[0];
          foreach (shadow_deque[i]) begin
            if (cmd == CMD_MIN ? shadow_deque[i] < r.data : shadow_deque[i] > r.data)
              r.data = shadow_deque[i];
          end
        end
      end
      CMD_READ_KTH, CMD_DELETE_KTH: begin
        if (k == 0 || k > n) begin
          r.st = ST_BAD_INDEX;
        end else begin
          r.data = shadow_deque[k-1];
          if (cmd == CMD_DELETE_KTH) shadow_deque.delete(k - 1);
        end
      end
      default: ;
    endcase
    r.occ   = IDX_W'(shadow_deque.size());
    r.empty = (shadow_deque.size() == 0);
    return r;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("[%0t] MISMATCH %s: got %0d expected %0d (response %0d)",
             $realtime, what, got, want, n_checked);
    n_errors++;
  endtask

  // Hold start low for a random burst of cycles.
  task automatic idle_burst();
    start = 1'b0;
    repeat ($urandom_range(1, 18)) @(negedge clk);
  endtask

  // Present one request and hold it until the engine takes it. Start stays
  // high afterwards so back-to-back requests need no extra edge.
  task automatic send_request(logic [3:0] cmd, logic signed [31:0] val,
                              logic [IDX_W-1:0] k);
    if (allow_gaps && $urandom_range(0, 3) == 0) idle_burst();
    command = cmd;
    value   = val;
    index   = k;
    start   = 1'b1;
    while (busy) @(negedge clk);
    @(posedge clk);
    pending_resp.push_back(apply_request(cmd, val, k));
    n_requests++;
    @(negedge clk);
  endtask

  // Compare every strobed response against the oldest prediction.
  always @(posedge clk) begin
    if (!rst && done) begin
      if (pending_resp.size() == 0) begin
        report_mismatch("unexpected response status", status, 0);
      end else begin
        deq_resp_t want;
        want = pending_resp.pop_front();
        if (data_out !== want.data)     report_mismatch("data_out", data_out, want.data);
        if (position !== want.pos)      report_mismatch("position", position, want.pos);
        if (match_count !== want.cnt)   report_mismatch("match_count", match_count, want.cnt);
        if (status !== want.st)         report_mismatch("status", status, want.st);
        if (occupancy !== want.occ)     report_mismatch("occupancy", occupancy, want.occ);
        if (is_empty !== want.empty)    report_mismatch("is_empty", is_empty, want.empty);
        n_checked++;
      end
    end
  end

  // Watchdog: count cycles in which no request is taken and no response lands.
  always @(posedge clk) begin
    if (rst || done || (start && !busy)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WDOG_MAX) begin
        $display("Watchdog expired after %0d quiet cycles", WDOG_MAX);
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  // Pick a value: extremes, a small pool so searches and counts hit, else random.
  function automatic logic signed [31:0] pick_value();
    case ($urandom_range(0, 9))
      0:       return 32'sh8000_0000;
      1:       return 32'sh7fff_ffff;
      2, 3, 4: return $urandom_range(0, 5) - 2;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [IDX_W-1:0] pick_index();
    int n;
    n = shadow_deque.size();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return IDX_W'(n + 1);
      2:       return IDX_W'($urandom_range(0, (1 << IDX_W) - 1));
      default: return (n == 0) ? IDX_W'(1) : IDX_W'($urandom_range(1, n));
    endcase
  endfunction

  // Empty deque: underflow on both pops, sentinel min/max, misses, bad index.
  task automatic test_empty_deque();
    send_request(CMD_POP_FRONT, 0, 0);
    send_request(CMD_POP_REAR, 0, 0);
    send_request(CMD_MIN, 0, 0);
    send_request(CMD_MAX, 0, 0);
    send_request(CMD_FIRST_POS, 0, 0);
    send_request(CMD_LAST_POS, 0, 0);
    send_request(CMD_COUNT, 0, 0);
    send_request(CMD_READ_KTH, 0, 1);
    send_request(CMD_DELETE_KTH, 0, 1);
  endtask

  // Both ends, value extremes, duplicates, search both ways, index edges.
  task automatic test_ends_and_search();
    send_request(CMD_PUSH_REAR, 32'sh7fff_ffff, 0);
    send_request(CMD_PUSH_FRONT, 32'sh8000_0000, 0);
    send_request(CMD_PUSH_REAR, 5, 0);
    send_request(CMD_PUSH_FRONT, 5, 0);
    send_request(CMD_FIRST_POS, 5, 0);
    send_request(CMD_LAST_POS, 5, 0);
    send_request(CMD_COUNT, 5, 0);
    send_request(CMD_MIN, 0, 0);
    send_request(CMD_MAX, 0, 0);
    send_request(CMD_READ_KTH, 0, 0);
    send_request(CMD_READ_KTH, 0, 5);
    send_request(CMD_READ_KTH, 0, {IDX_W{1'b1}});
    send_request(CMD_DELETE_KTH, 0, 2);
    send_request(CMD_POP_REAR, 0, 0);
    send_request(CMD_POP_FRONT, 0, 0);
  endtask

  // Commands 11..15 change nothing.
  task automatic test_unknown_commands();
    for (int c = 11; c < 16; c++) send_request(4'(c), $urandom, IDX_W'($urandom));
  endtask

  // Fill to capacity, hit the full case and work at full; random traffic
  // afterwards works the occupancy down from there.
  task automatic test_full_deque();
    while (shadow_deque.size() < DEPTH) send_request(CMD_PUSH_REAR, pick_value(), 0);
    send_request(CMD_PUSH_FRONT, 1, 0);
    send_request(CMD_PUSH_REAR, 1, 0);
    send_request(CMD_READ_KTH, 0, IDX_W'(DEPTH));
    send_request(CMD_READ_KTH, 0, IDX_W'(DEPTH + 1));
    send_request(CMD_MIN, 0, 0);
    send_request(CMD_LAST_POS, 32'sh7fff_ffff, 0);
    send_request(CMD_DELETE_KTH, 0, 1);
    send_request(CMD_DELETE_KTH, 0, IDX_W'(DEPTH - 1));
  endtask

  // Mixed random traffic; occupancy drifts around a moving target.
  task automatic test_random_traffic(int count);
    int target;
    logic [3:0] cmd;
    target = 8;
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(0, 49) == 0) target = $urandom_range(0, 48);
      if ($urandom_range(0, 2) == 0)
        cmd = (shadow_deque.size() < target) ? 4'(CMD_PUSH_FRONT + $urandom_range(0, 1))
                                             : 4'(CMD_POP_FRONT + $urandom_range(0, 1));
      else if ($urandom_range(0, 29) == 0)
        cmd = 4'($urandom_range(11, 15));
      else
        cmd = 4'($urandom_range(CMD_PUSH_FRONT, CMD_DELETE_KTH));
      send_request(cmd, pick_value(), pick_index());
    end
  endtask

  initial begin
    rst         = 1'b1;
    start       = 1'b0;
    command     = CMD_PUSH_FRONT;
    value       = '0;
    index       = '0;
    allow_gaps  = 1'b1;
    repeat (6) @(negedge clk);
    rst = 1'b0;

    test_empty_deque();
    test_ends_and_search();
    test_unknown_commands();
    test_random_traffic(150);
    test_full_deque();
    test_random_traffic(50);
    // Final stretch runs back to back with no gaps.
    allow_gaps = 1'b0;
    test_random_traffic(100);

    start = 1'b0;
    while (pending_resp.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);

    $display("Covered %0d requests incl. empty, full, extreme values and bad indexes;",
             n_requests);
    $display("%0d responses checked, %0d mismatches", n_checked, n_errors);
    if (n_errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
